[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the step trigger checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PDS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/pds_pkg.sv]
// ----------------------------------------------------------------------------
// pds_pkg
// shared widths, register indexes, types and helpers of the step trigger
// ----------------------------------------------------------------------------
package pds_pkg;

    localparam int PHASE_W     = 24;
    localparam int FRAC_BITS   = 22;
    localparam int DIV_W       = 8;
    localparam int SLOT_CNT_W  = 4;
    localparam int STEP_W      = 8;
    localparam int MAX_SLOTS   = 8;
    localparam int STEPS_W     = MAX_SLOTS * STEP_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int PROD_W      = FRAC_BITS + DIV_W;
    localparam int DIVIDEND_W  = STEP_W + 1;
    localparam int MOD_CNT_W   = $clog2(DIVIDEND_W);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_STEPS = 2'd2;

    typedef enum logic [1:0] {
        MOD_IDLE,
        MOD_RUN,
        MOD_DONE
    } mod_state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIV_W-1:0]      divisor;
    } mod_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [STEP_W-1:0] rem;
    } mod_res_t;

    typedef struct packed {
        logic [FRAC_BITS-1:0] scaled;
        logic [MAX_SLOTS-1:0] fire_mask;
        logic                 wrapped;
        logic                 stopped;
        logic [STEP_W-1:0]    counter;
        logic [STEP_W-1:0]    next_step;
    } step_res_t;

    // divider of zero acts as one
    function automatic logic [DIV_W-1:0] eff_divider(input logic [DIV_W-1:0] d);
        eff_divider = (d == '0) ? DIV_W'(1) : d;
    endfunction

    // one enable bit per active slot, count clamped to 1..MAX_SLOTS
    function automatic logic [MAX_SLOTS-1:0] slot_enable(input logic [SLOT_CNT_W-1:0] n);
        logic [SLOT_CNT_W-1:0] cnt;
        logic [MAX_SLOTS-1:0]  en;
        cnt = n;
        if (cnt == '0)
        begin
            cnt = SLOT_CNT_W'(1);
        end
        if (cnt > SLOT_CNT_W'(MAX_SLOTS))
        begin
            cnt = SLOT_CNT_W'(MAX_SLOTS);
        end
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            en[k] = (SLOT_CNT_W'(k) < cnt);
        end
        slot_enable = en;
    endfunction

endpackage

[rtl/core/pds_mod_unit.sv]
// ----------------------------------------------------------------------------
// pds_mod_unit
// bit-serial remainder of a small dividend by the divider, one bit a cycle
// ----------------------------------------------------------------------------
module pds_mod_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  pds_pkg::mod_req_t req,
    output pds_pkg::mod_res_t res
);
    import pds_pkg::*;

    mod_state_t            state_reg, state_next;
    logic [STEP_W-1:0]     rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [MOD_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MOD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        shifted    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        case (state_reg)
            MOD_IDLE:
            begin
                if (req.start)
                begin
                    rem_next   = '0;
                    quo_next   = req.dividend;
                    cnt_next   = MOD_CNT_W'(DIVIDEND_W - 1);
                    state_next = MOD_RUN;
                end
            end
            MOD_RUN:
            begin
                // partial remainder stays below twice the divisor
                if (shifted >= {1'b0, req.divisor})
                begin
                    rem_next = STEP_W'(shifted - {1'b0, req.divisor});
                end
                else
                begin
                    rem_next = shifted[STEP_W-1:0];
                end
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    state_next = MOD_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            MOD_DONE:
            begin
                state_next = MOD_IDLE;
            end
            default:
            begin
                state_next = MOD_IDLE;
            end
        endcase
    end

    assign res.busy = (state_reg != MOD_IDLE);
    assign res.done = (state_reg == MOD_DONE);
    assign res.rem  = rem_reg;

endmodule

[rtl/core/pds_step_unit.sv]
// ----------------------------------------------------------------------------
// pds_step_unit
// scales one phasor sample, detects wrap or stop and matches the step slots
// ----------------------------------------------------------------------------
module pds_step_unit (
    input  logic signed [pds_pkg::PHASE_W-1:0]    phase,
    input  logic        [pds_pkg::FRAC_BITS-1:0]  last_phase,
    input  logic        [pds_pkg::STEP_W-1:0]     counter,
    input  logic        [pds_pkg::STEP_W-1:0]     next_step,
    input  logic        [pds_pkg::DIV_W-1:0]      div,
    input  logic        [pds_pkg::STEPS_W-1:0]    slot_steps,
    input  logic        [pds_pkg::MAX_SLOTS-1:0]  slot_en,
    output pds_pkg::step_res_t                    res
);
    import pds_pkg::*;

    logic [PHASE_W-1:0]   raw;
    logic [PHASE_W-1:0]   mag;
    logic [PROD_W-1:0]    prod;
    logic [FRAC_BITS-1:0] scaled;
    logic                 wrap;
    logic                 stop;
    logic [STEP_W-1:0]    lim;
    logic [STEP_W-1:0]    step_k;
    logic [MAX_SLOTS-1:0] hit;
    logic [STEP_W:0]      inc;

    always_comb
    begin
        raw    = phase;
        // magnitude, most negative value maps to 2^23 on its own
        mag    = raw[PHASE_W-1] ? PHASE_W'(~raw + 1'b1) : raw;
        prod   = PROD_W'(mag[FRAC_BITS-1:0]) * PROD_W'(div);
        scaled = prod[FRAC_BITS-1:0];
        wrap   = (scaled < last_phase);
        stop   = (scaled == last_phase);
        lim    = div - 1'b1;

        step_k = '0;
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            step_k = slot_steps[k*STEP_W +: STEP_W];
            if (step_k > lim)
            begin
                step_k = lim;
            end
            hit[k] = slot_en[k] && (step_k == counter);
        end

        inc = {1'b0, next_step} + 1'b1;

        res.scaled    = scaled;
        res.wrapped   = wrap;
        res.stopped   = stop;
        res.fire_mask = wrap ? hit : '0;
        if (wrap)
        begin
            res.counter   = next_step;
            res.next_step = (inc == {1'b0, div}) ? '0 : inc[STEP_W-1:0];
        end
        else if (stop)
        begin
            res.counter   = '0;
            res.next_step = (div == DIV_W'(1)) ? '0 : STEP_W'(1);
        end
        else
        begin
            res.counter   = counter;
            res.next_step = next_step;
        end
    end

endmodule

[rtl/core/phase_divider_step_trigger.sv]
// ----------------------------------------------------------------------------
// phase_divider_step_trigger
// phasor clock divider with per-slot step triggers
// ----------------------------------------------------------------------------
// an accepted input word passes the input stage, then the result stage
// throughput: one word per cycle unless stalled; single 22x8 multiply
// a divider write holds the pipeline while the bit-serial
// remainder unit refreshes the precomputed next step
// reset: async active low, divider 1, slot count 1, steps 0, state cleared
// ----------------------------------------------------------------------------
module phase_divider_step_trigger (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [pds_pkg::PHASE_W-1:0]  phase_in,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic        [pds_pkg::MAX_SLOTS-1:0] fire_mask,
    output logic                                wrapped,
    output logic                                stopped,
    output logic        [pds_pkg::STEP_W-1:0]   step_now,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [pds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [pds_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pds_pkg::*;

    // configuration registers
    logic [DIV_W-1:0]      divider_reg;
    logic [SLOT_CNT_W-1:0] slot_count_reg;
    logic [STEPS_W-1:0]    slot_steps_reg;

    // running state: scaled phase, counter, and the counter value a wrap
    // would produce, kept ready so no modulo sits in the datapath
    logic [FRAC_BITS-1:0]  last_phase_reg;
    logic [STEP_W-1:0]     counter_reg;
    logic [STEP_W-1:0]     next_step_reg;

    // input stage
    logic                  s1_valid_reg, s1_valid_next;
    logic signed [PHASE_W-1:0] s1_phase_reg;

    // result stage
    logic                  out_valid_reg, out_valid_next;
    logic [MAX_SLOTS-1:0]  fire_mask_reg;
    logic                  wrapped_reg;
    logic                  stopped_reg;
    logic [STEP_W-1:0]     step_now_reg;

    logic                  mod_start_reg, mod_start_next;
    logic                  busy;
    logic                  cfg_we;
    logic                  in_take;
    logic                  advance;
    logic [DIV_W-1:0]      eff_div;
    logic [MAX_SLOTS-1:0]  slot_en;
    step_res_t             step_res;
    mod_req_t              mod_req;
    mod_res_t              mod_res;

    assign eff_div = eff_divider(divider_reg);
    assign slot_en = slot_enable(slot_count_reg);

    // the remainder unit owns the counter state while it runs
    assign busy      = mod_start_reg || mod_res.busy;
    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    // input word moves on if not busy and result register is free or drained
    assign advance   = s1_valid_reg && !busy && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);
    assign mod_start_next = cfg_we && (cfg_index == REG_DIVIDER);

    assign mod_req.start    = mod_start_reg;
    assign mod_req.dividend = {1'b0, counter_reg} + 1'b1;
    assign mod_req.divisor  = eff_div;

    pds_step_unit u_step (
        .phase      (s1_phase_reg),
        .last_phase (last_phase_reg),
        .counter    (counter_reg),
        .next_step  (next_step_reg),
        .div        (eff_div),
        .slot_steps (slot_steps_reg),
        .slot_en    (slot_en),
        .res        (step_res)
    );

    pds_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .res   (mod_res)
    );

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            mod_start_reg  <= 1'b0;
            divider_reg    <= DIV_W'(1);
            slot_count_reg <= SLOT_CNT_W'(1);
            slot_steps_reg <= '0;
            last_phase_reg <= '0;
            counter_reg    <= '0;
            next_step_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            mod_start_reg <= mod_start_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DIVIDER:    divider_reg    <= cfg_data[DIV_W-1:0];
                    REG_SLOT_COUNT: slot_count_reg <= cfg_data[SLOT_CNT_W-1:0];
                    REG_SLOT_STEPS: slot_steps_reg <= cfg_data[STEPS_W-1:0];
                    default:        ;
                endcase
            end
            if (advance)
            begin
                last_phase_reg <= step_res.scaled;
                counter_reg    <= step_res.counter;
                next_step_reg  <= step_res.next_step;
            end
            else if (mod_res.done)
            begin
                // (counter + 1) mod divider after a divider change
                next_step_reg <= mod_res.rem;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_phase_reg <= phase_in;
        end
        if (advance)
        begin
            fire_mask_reg <= step_res.fire_mask;
            wrapped_reg   <= step_res.wrapped;
            stopped_reg   <= step_res.stopped;
            step_now_reg  <= step_res.counter;
        end
    end

    assign out_valid = out_valid_reg;
    assign fire_mask = fire_mask_reg;
    assign wrapped   = wrapped_reg;
    assign stopped   = stopped_reg;
    assign step_now  = step_now_reg;

endmodule

[rtl/core/pds_checker.sv]
// ----------------------------------------------------------------------------
// pds_checker
// port-level checks of the step trigger, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pds_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic signed [pds_pkg::PHASE_W-1:0]   phase_in,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic        [pds_pkg::MAX_SLOTS-1:0] fire_mask,
    input logic                                 wrapped,
    input logic                                 stopped,
    input logic        [pds_pkg::STEP_W-1:0]    step_now
);
    import pds_pkg::*;

    // all result fields as one word
    logic [MAX_SLOTS+STEP_W+1:0] out_word;

    assign out_word = {fire_mask, wrapped, stopped, step_now};

    // a stalled input word keeps its payload
    `PDS_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(phase_in))

    // a held result word keeps its fields
    `PDS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

    // wrap and stop exclude each other
    `PDS_ASSERT_SAME(a_wrap_stop, out_valid, !(wrapped && stopped))

    // triggers only come with a wrap
    `PDS_ASSERT_SAME(a_fire_wrap, out_valid && (fire_mask != '0), wrapped)

    // a stop always returns the counter to zero
    `PDS_ASSERT_SAME(a_stop_zero, out_valid && stopped, step_now == '0)

endmodule

bind phase_divider_step_trigger pds_checker u_pds_checker (.*);
